### design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared codes, stream widths and controller/datapath interface types for the
// circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// Action codes (codes 5..7 behave as no operation)
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_NONE       = 3'd4;

	// Status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	// Stream widths, padded to whole bytes
	localparam int IN_W  = 40;
	localparam int OUT_W = 72;

	// Result word bit positions
	localparam int OUT_EMPTY_BIT = 66;
	localparam int OUT_FULL_BIT  = 67;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the accepted transaction
		logic exec;   // apply the action to indices, store and caches
		logic fetch;  // take the registered store read into a cache
		logic emit;   // move the result into the output register
	} cdq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_fetch; // pop left words behind; new end word must be read
		logic out_free;   // output register can take a result this cycle
	} cdq_sts_t;

endpackage

### design/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: accept, execute, optional slot fetch, emit result.
// ----------------------------------------------------------------------------
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  cdq_sts_t sts,
	output cdq_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_RESULT = 4'b1000
	} cdq_state_t;

	cdq_state_t state_q;
	cdq_state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_fetch ? ST_FETCH : ST_RESULT;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: head/tail indices, empty flag, slot memory, cached front
// and back words, and the output register.
// ----------------------------------------------------------------------------
module cdq_dpath
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	input  cdq_cmd_t         cmd,
	output cdq_sts_t         sts
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	// Captured transaction
	logic [2:0]         act_q;
	logic signed [31:0] val_q;

	// Queue state
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          empty_q;
	logic          fetch_front_q;

	// Cached end words
	logic signed [31:0] front_q;
	logic signed [31:0] back_q;
	logic [1:0]         status_q;

	// Slot memory
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_q;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;

	// Output register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	// Index stepping helpers
	logic [IW-1:0] head_nxt, head_prv, tail_nxt, tail_prv;
	logic          full;
	logic          is_push, is_pop;

	assign head_nxt = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_prv = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_nxt = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_prv = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign full     = !empty_q && (tail_nxt == head_q);

	assign is_push = (act_q == ACT_PUSH_BACK) || (act_q == ACT_PUSH_FRONT);
	assign is_pop  = (act_q == ACT_POP_FRONT) || (act_q == ACT_POP_BACK);

	// Memory port control for the execute step, status back to the controller
	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = '0;
		rd_addr        = head_nxt;
		sts.need_fetch = 1'b0;
		sts.out_free   = !out_valid_q || m_tready;
		if (cmd.exec) begin
			if (is_push && !full) begin
				wr_en = 1'b1;
				if (empty_q) begin
					wr_addr = '0;
				end else if (act_q == ACT_PUSH_BACK) begin
					wr_addr = tail_nxt;
				end else begin
					wr_addr = head_prv;
				end
			end
			if (is_pop && !empty_q && (head_q != tail_q)) begin
				sts.need_fetch = 1'b1;
				rd_addr        = (act_q == ACT_POP_FRONT) ? head_nxt : tail_prv;
			end
		end
	end

	// Slot memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= val_q;
		end
		rd_q <= mem[rd_addr];
	end

	// Control state: indices, empty flag, fetch target, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			empty_q       <= 1'b1;
			fetch_front_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (is_push && !full) begin
					if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else if (act_q == ACT_PUSH_BACK) begin
						tail_q <= tail_nxt;
					end else begin
						head_q <= head_prv;
					end
				end else if (is_pop && !empty_q) begin
					if (head_q == tail_q) begin
						empty_q <= 1'b1;
					end else if (act_q == ACT_POP_FRONT) begin
						head_q        <= head_nxt;
						fetch_front_q <= 1'b1;
					end else begin
						tail_q        <= tail_prv;
						fetch_front_q <= 1'b0;
					end
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: captured transaction, caches, status, result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tdata[2:0];
			val_q <= s_tdata[34:3];
		end
		if (cmd.exec) begin
			status_q <= STS_DONE;
			if (is_push) begin
				if (full) begin
					status_q <= STS_FULL;
				end else if (empty_q) begin
					front_q <= val_q;
					back_q  <= val_q;
				end else if (act_q == ACT_PUSH_BACK) begin
					back_q <= val_q;
				end else begin
					front_q <= val_q;
				end
			end else if (is_pop && empty_q) begin
				status_q <= STS_EMPTY;
			end
		end
		if (cmd.fetch) begin
			if (fetch_front_q) begin
				front_q <= rd_q;
			end else begin
				back_q <= rd_q;
			end
		end
		if (cmd.emit) begin
			out_q <= {4'b0000, full, empty_q,
				empty_q ? 32'hFFFF_FFFF : back_q,
				empty_q ? 32'hFFFF_FFFF : front_q,
				status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### design/circular_double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue_core
// Double-ended queue of 32-bit signed words in a circular slot memory.
// ----------------------------------------------------------------------------
// Each input transaction carries one action (push back, push front, pop front,
// pop back, none) and yields exactly one result transaction with a status
// code, the front and back words after the action (-1 when empty) and the
// empty and full flags. Each transaction passes the execute state and, for a
// pop that leaves words behind, a fetch state, where the registered read of
// the slot memory brings in the new end word; the result state then moves
// its result into the output register. The front and back words are cached
// in registers, so pushes need no read. A new transaction is accepted as soon
// as the previous result sits in the output register; it holds its result
// until that register is free. The slot memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_core
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// [2:0] action, [34:3] value, [39:35] zero
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// [1:0] status, [33:2] front_value, [65:34] back_value,
	// [66] is_empty, [67] is_full, [71:68] zero
	output logic [OUT_W-1:0] m_tdata
);

	cdq_cmd_t cmd;
	cdq_sts_t sts;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// One transaction in flight: accept drops ready for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a transaction is in flight");

	// Empty queue reports -1 at both ends
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_EMPTY_BIT] |->
		(m_tdata[33:2] == 32'hFFFF_FFFF) && (m_tdata[65:34] == 32'hFFFF_FFFF))
		else $error("empty result with end words not -1");

	// Empty and full never together
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[OUT_EMPTY_BIT] && m_tdata[OUT_FULL_BIT]))
		else $error("result both empty and full");

	// Rejected push leaves the queue full; rejected pop leaves it empty
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == STS_FULL) |-> m_tdata[OUT_FULL_BIT])
		else $error("push rejected but queue not full");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == STS_EMPTY) |-> m_tdata[OUT_EMPTY_BIT])
		else $error("pop rejected but queue not empty");

endmodule

### dv/circular_double_ended_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_core_test
// Self-checking bench for the circular double-ended queue core.
// ----------------------------------------------------------------------------
// A short table of directed transactions covers the empty and unused-code
// cases, word extremes and the drain back to empty. The random part then
// runs fill, drain and mixed stretches, with rejected pushes on a full queue,
// rejected pops on an empty one, and no-op codes as noise. Every accepted
// transaction goes through a local deque model. Every result is compared
// field by field with the oldest pending expectation. The sender works in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_core_test;
	import cdq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int END_HOLD       = 16;
	localparam int MAX_REPORTS    = 10;
	localparam int DIR_ROWS       = 18;

	// Codes outside the package that the core treats as no operation
	localparam logic [2:0] ACT_SPARE_5 = 3'd5;
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam logic [31:0] NO_WORD = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] front_value;
		logic [31:0] back_value;
		logic        is_empty;
		logic        is_full;
	} deque_result_t;

	typedef struct packed {
		logic [2:0]    action;
		logic [31:0]   value;
		logic          typed;   // result written into the table
		deque_result_t result;
	} dir_row_t;

	typedef enum logic [1:0] {SHAPE_FILL, SHAPE_DRAIN, SHAPE_MIX} shape_t;
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	// [2:0] action, [34:3] value, [39:35] zero
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	// [1:0] status, [33:2] front_value, [65:34] back_value,
	// [66] is_empty, [67] is_full, [71:68] zero
	logic [OUT_W-1:0] m_tdata;

	circular_double_ended_queue_core #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Deque model state
	logic [31:0] deque_words [DEPTH];
	int          front_idx;
	int          back_idx;
	logic        deque_is_empty;

	// Pending results, oldest first
	deque_result_t pending_results [$];

	// Table row that travels with the transaction being offered
	logic          drv_typed;
	deque_result_t drv_result;

	int error_count;
	int idle_cycles;

	dir_row_t dir_table [DIR_ROWS];

	function automatic int wrap_inc(input int i);
		return (i + 1 >= DEPTH) ? 0 : i + 1;
	endfunction

	function automatic int wrap_dec(input int i);
		return (i == 0) ? DEPTH - 1 : i - 1;
	endfunction

	function automatic logic deque_full();
		return !deque_is_empty && wrap_inc(back_idx) == front_idx;
	endfunction

	// Apply one action to the model and return the queue as it then stands
	task automatic apply_deque_action(input logic [2:0] action, input logic [31:0] value,
			output deque_result_t res);
		logic [1:0] status;
		status = STS_DONE;
		if (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT) begin
			if (deque_full()) begin
				status = STS_FULL;
			end else if (deque_is_empty) begin
				front_idx      = 0;
				back_idx       = 0;
				deque_words[0] = value;
				deque_is_empty = 1'b0;
			end else if (action == ACT_PUSH_BACK) begin
				back_idx              = wrap_inc(back_idx);
				deque_words[back_idx] = value;
			end else begin
				front_idx              = wrap_dec(front_idx);
				deque_words[front_idx] = value;
			end
		end else if (action == ACT_POP_FRONT || action == ACT_POP_BACK) begin
			if (deque_is_empty)
				status = STS_EMPTY;
			else if (front_idx == back_idx)
				deque_is_empty = 1'b1;
			else if (action == ACT_POP_FRONT)
				front_idx = wrap_inc(front_idx);
			else
				back_idx = wrap_dec(back_idx);
		end
		res.status      = status;
		res.front_value = deque_is_empty ? NO_WORD : deque_words[front_idx];
		res.back_value  = deque_is_empty ? NO_WORD : deque_words[back_idx];
		res.is_empty    = deque_is_empty;
		res.is_full     = deque_full();
	endtask

	task automatic report_mismatch(input string what, input deque_result_t want,
			input deque_result_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t %s: exp sts=%0d f=%0d b=%0d e=%0b u=%0b act sts=%0d f=%0d b=%0d e=%0b u=%0b",
				$realtime, what, want.status, $signed(want.front_value),
				$signed(want.back_value), want.is_empty, want.is_full, got.status,
				$signed(got.front_value), $signed(got.back_value), got.is_empty,
				got.is_full);
	endtask

	// Monitor: check the result side first, then predict the input side
	always @(posedge clk) begin
		deque_result_t got;
		deque_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status      = m_tdata[1:0];
				got.front_value = m_tdata[33:2];
				got.back_value  = m_tdata[65:34];
				got.is_empty    = m_tdata[OUT_EMPTY_BIT];
				got.is_full     = m_tdata[OUT_FULL_BIT];
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (got.status !== want.status ||
							got.front_value !== want.front_value ||
							got.back_value !== want.back_value ||
							got.is_empty !== want.is_empty ||
							got.is_full !== want.is_full)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready) begin
				apply_deque_action(s_tdata[2:0], s_tdata[34:3], want);
				pending_results.insert(pending_results.size(),
					drv_typed ? drv_result : want);
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver: randomly chosen stretches of open, random and sparse readiness
	rx_mode_t rx_mode;
	int       rx_left;
	int       rx_tick;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(10, 60);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
			default:   m_tready <= (rx_tick % 3 == 0);
		endcase
	end

	// Sender: bursts of random length separated by short gaps
	int burst_left;

	task automatic send_action(input logic [2:0] action, input logic [31:0] value,
			input logic typed, input deque_result_t res);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid   <= 1'b1;
		s_tdata    <= {5'b0, value, action};
		drv_typed  <= typed;
		drv_result <= res;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return NO_WORD;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus
	initial begin
		shape_t      shape;
		int          shape_left;
		int          fill_level;
		int          sent;
		int          roll;
		logic [2:0]  action;
		logic [31:0] value;

		arst_n         <= 1'b0;
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		m_tready       <= 1'b0;
		drv_typed      <= 1'b0;
		drv_result     <= '0;
		error_count    = 0;
		idle_cycles    = 0;
		rx_left        = 0;
		rx_tick        = 0;
		burst_left     = 0;
		front_idx      = 0;
		back_idx       = 0;
		deque_is_empty = 1'b1;
		foreach (deque_words[i]) deque_words[i] = '0;

		// Empty queue, unused codes, extremes, drain and single-word cases
		dir_table[0]  = '{ACT_POP_FRONT, 32'h0, 1'b1, '{STS_EMPTY, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[1]  = '{ACT_POP_BACK, 32'h0, 1'b1, '{STS_EMPTY, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[2]  = '{ACT_NONE, 32'h1234_5678, 1'b1,
			'{STS_DONE, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[3]  = '{ACT_SPARE_5, 32'h0, 1'b1, '{STS_DONE, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[4]  = '{ACT_SPARE_6, 32'h0, 1'b1, '{STS_DONE, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[5]  = '{ACT_SPARE_7, NO_WORD, 1'b1, '{STS_DONE, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[6]  = '{ACT_PUSH_BACK, 32'h7FFF_FFFF, 1'b1,
			'{STS_DONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}};
		dir_table[7]  = '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1,
			'{STS_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}};
		dir_table[8]  = '{ACT_PUSH_BACK, 32'h0, 1'b0, '0};
		dir_table[9]  = '{ACT_PUSH_FRONT, NO_WORD, 1'b0, '0};
		dir_table[10] = '{ACT_NONE, 32'hA5A5_A5A5, 1'b0, '0};
		dir_table[11] = '{ACT_POP_FRONT, 32'h0, 1'b0, '0};
		dir_table[12] = '{ACT_POP_BACK, 32'h0, 1'b0, '0};
		dir_table[13] = '{ACT_POP_FRONT, 32'h0, 1'b0, '0};
		dir_table[14] = '{ACT_POP_BACK, 32'h0, 1'b0, '0};
		dir_table[15] = '{ACT_POP_BACK, 32'h0, 1'b1, '{STS_EMPTY, NO_WORD, NO_WORD, 1'b1, 1'b0}};
		dir_table[16] = '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b1,
			'{STS_DONE, 32'h5555_5555, 32'h5555_5555, 1'b0, 1'b0}};
		dir_table[17] = '{ACT_POP_FRONT, 32'h0, 1'b1, '{STS_DONE, NO_WORD, NO_WORD, 1'b1, 1'b0}};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_action(dir_table[i].action, dir_table[i].value, dir_table[i].typed,
				dir_table[i].result);

		// Random part: fill and drain runs that hit the full and empty limits
		shape      = SHAPE_FILL;
		shape_left = $urandom_range(1, 4);
		fill_level = 0;
		sent       = 0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			case (shape)
				SHAPE_FILL:  action = (roll < 80) ? ACT_PUSH_BACK : (roll < 90) ? ACT_POP_FRONT
					: ACT_NONE;
				SHAPE_DRAIN: action = (roll < 80) ? ACT_POP_FRONT : (roll < 90) ? ACT_PUSH_BACK
					: ACT_NONE;
				default:     action = (roll < 45) ? ACT_PUSH_BACK : (roll < 90) ? ACT_POP_FRONT
					: ACT_NONE;
			endcase
			// Pick the end at random, or a random no-op code for noise
			if (action == ACT_PUSH_BACK)
				action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
			else if (action == ACT_POP_FRONT)
				action = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
			else
				action = 3'($urandom_range(ACT_NONE, ACT_SPARE_7));
			value = pick_word();

			send_action(action, value, 1'b0, '0);
			sent++;

			if (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT) begin
				if (fill_level < DEPTH) fill_level++;
			end else if (action == ACT_POP_FRONT || action == ACT_POP_BACK) begin
				if (fill_level > 0) fill_level--;
			end

			if ((shape == SHAPE_FILL && fill_level == DEPTH) ||
					(shape == SHAPE_DRAIN && fill_level == 0) || shape == SHAPE_MIX)
				shape_left--;
			if (shape_left <= 0) begin
				shape      = shape_t'($urandom_range(0, 2));
				shape_left = (shape == SHAPE_MIX) ? $urandom_range(10, 50)
					: $urandom_range(1, 4);
			end
		end
		s_tvalid <= 1'b0;

		// Drain the pending results, then watch for stray ones
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (END_HOLD) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### circular_double_ended_queue_core.f
design/cdq_pkg.sv
design/cdq_ctrl.sv
design/cdq_dpath.sv
design/circular_double_ended_queue_core.sv
dv/circular_double_ended_queue_core_test.sv
